>>> src/ternary_packed_matvec_core_defines.svh
// Assertion macros for the ternary packed matrix-vector core
`ifndef TERNARY_PACKED_MATVEC_CORE_DEFINES_SVH
`define TERNARY_PACKED_MATVEC_CORE_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define TPMV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define TPMV_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tpmv_pkg.sv
// Types, constants and codes shared by the ternary packed matrix-vector core
package tpmv_pkg;

	localparam int MAX_COLS = 4096;
	localparam int ACT_W    = 16;
	localparam int TRITS    = 4;
	localparam int TRIT_W   = 2;
	localparam int SUM_W    = 32;
	localparam int ROWS_W   = 16;
	localparam int CFG_W    = 16;

	localparam int IDX_W    = $clog2(MAX_COLS);
	localparam int TSEL_W   = $clog2(TRITS);
	localparam int ROW_AW   = $clog2(MAX_COLS / TRITS);
	localparam int ROW_DEPTH = MAX_COLS / TRITS;
	localparam int COL_W    = $clog2(MAX_COLS) + 1;
	localparam int BYTE_W   = TRITS * TRIT_W;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	localparam logic [TRIT_W-1:0] TRIT_POS = 2'b01;
	localparam logic [TRIT_W-1:0] TRIT_NEG = 2'b10;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DONE
	} tpmv_state_t;

	typedef struct packed {
		logic                    operation;
		logic [IDX_W-1:0]        act_index;
		logic signed [ACT_W-1:0] act_value;
		logic [BYTE_W-1:0]       weight_byte;
	} tpmv_in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] row_sum;
		logic [ROWS_W-1:0]       row_index;
		logic                    last_row;
	} tpmv_out_t;

	typedef struct packed {
		logic              load_act;
		logic              latch_byte;
		logic              acc_step;
		logic [TSEL_W-1:0] trit;
		logic              adv_byte;
		logic              emit;
	} tpmv_cmd_t;

	typedef struct packed {
		logic row_end;
		logic out_free;
	} tpmv_sts_t;

endpackage

>>> src/tpmv_ctrl.sv
// Sequencer: item acceptance, per-trit accumulate steps and row completion
module tpmv_ctrl import tpmv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      operation,
	output logic      item_stall,
	input  tpmv_sts_t sts,
	output tpmv_cmd_t cmd
);

	tpmv_state_t       state_q, state_d;
	logic [TSEL_W-1:0] trit_q;
	logic              accept;
	logic              last_trit;

	assign accept    = item_valid && (state_q == ST_IDLE);
	assign last_trit = (trit_q == TSEL_W'(TRITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				trit_q <= last_trit ? '0 : trit_q + TSEL_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_WEIGHT) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (last_trit) begin
					state_d = sts.row_end ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall     = (state_q != ST_IDLE);
		cmd            = '0;
		cmd.trit       = trit_q;
		cmd.load_act   = accept && operation == OP_LOAD;
		cmd.latch_byte = accept && operation == OP_WEIGHT;
		cmd.acc_step   = (state_q == ST_ACC);
		cmd.adv_byte   = (state_q == ST_ACC) && last_trit && !sts.row_end;
		cmd.emit       = (state_q == ST_DONE) && sts.out_free;
	end

endmodule

>>> src/tpmv_dp.sv
// Datapath: activation banks, saturating row accumulator, counters and result register
module tpmv_dp import tpmv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tpmv_in_t         item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  tpmv_cmd_t        cmd,
	output tpmv_sts_t        sts,
	input  logic             result_stall,
	output logic             result_valid,
	output tpmv_out_t        result
);

	logic [COL_W-1:0]        cols_q;
	logic [ROWS_W-1:0]       rows_q;
	logic [ROW_AW-1:0]       byte_pos_q;
	logic [ROWS_W-1:0]       row_q;
	logic signed [SUM_W-1:0] acc_q;
	logic [BYTE_W-1:0]       wbyte_q;
	logic [ACT_W-1:0]        rd_q [TRITS];
	logic                    result_valid_q;
	tpmv_out_t               result_q;

	logic [COL_W-1:0]        cols_eff;
	logic [COL_W:0]          cols_pad;
	logic [COL_W-2:0]        bytes_per_row;
	logic [ROW_AW:0]         byte_next;
	logic [COL_W-1:0]        col;
	logic [TRIT_W-1:0]       code;
	logic signed [ACT_W-1:0] act;
	logic signed [ACT_W:0]   addend;
	logic signed [SUM_W:0]   sum;
	logic signed [SUM_W-1:0] sum_sat;
	logic                    last;

	// activation banks: one per trit lane, one row per packed byte
	for (genvar l = 0; l < TRITS; l++) begin : g_bank
		logic [ACT_W-1:0] mem_q [ROW_DEPTH];

		always_ff @(posedge clk) begin
			if (cmd.load_act && item.act_index[TSEL_W-1:0] == TSEL_W'(l)) begin
				mem_q[item.act_index[IDX_W-1:TSEL_W]] <= item.act_value;
			end
			if (cmd.latch_byte) begin
				rd_q[l] <= mem_q[byte_pos_q];
			end
		end
	end

	always_comb begin
		cols_eff = cols_q;
		if (cols_q == '0) begin
			cols_eff = COL_W'(1);
		end else if (cols_q > COL_W'(MAX_COLS)) begin
			cols_eff = COL_W'(MAX_COLS);
		end
		cols_pad      = {1'b0, cols_eff} + (COL_W + 1)'(TRITS - 1);
		bytes_per_row = cols_pad[COL_W:TSEL_W];
		byte_next     = {1'b0, byte_pos_q} + (ROW_AW + 1)'(1);
		sts.row_end   = {1'b0, byte_next} >= bytes_per_row;
		sts.out_free  = !result_valid_q || !result_stall;
		last          = (row_q == rows_q - ROWS_W'(1));
	end

	always_comb begin
		col    = {1'b0, byte_pos_q, cmd.trit};
		code   = wbyte_q[cmd.trit * TRIT_W +: TRIT_W];
		act    = rd_q[cmd.trit];
		addend = '0;
		if (col < cols_eff) begin
			unique case (code)
				TRIT_POS: addend = (ACT_W + 1)'(act);
				TRIT_NEG: addend = -((ACT_W + 1)'(act));
				default:  addend = '0;
			endcase
		end
		sum = (SUM_W + 1)'(acc_q) + (SUM_W + 1)'(addend);
		if (sum[SUM_W] != sum[SUM_W-1]) begin
			sum_sat = sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_byte) begin
			wbyte_q <= item.weight_byte;
		end
		if (cmd.emit) begin
			result_q.row_sum   <= acc_q;
			result_q.row_index <= row_q;
			result_q.last_row  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q         <= COL_W'(MAX_COLS);
			rows_q         <= ROWS_W'(1024);
			byte_pos_q     <= '0;
			row_q          <= '0;
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COLS: cols_q <= cfg_data[COL_W-1:0];
					CFG_ROWS: rows_q <= cfg_data[ROWS_W-1:0];
					default:  rows_q <= rows_q;
				endcase
			end
			if (cmd.acc_step) begin
				acc_q <= sum_sat;
			end
			if (cmd.adv_byte) begin
				byte_pos_q <= byte_next[ROW_AW-1:0];
			end
			if (cmd.emit) begin
				acc_q          <= '0;
				byte_pos_q     <= '0;
				row_q          <= last ? '0 : row_q + ROWS_W'(1);
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> src/ternary_packed_matvec_core.sv
// Ternary packed matrix-vector core: activation load and weight byte accumulation
// Activation load beat: written to its bank on acceptance; the core stays idle, so the next
// beat is accepted in the following cycle. Weight byte beat: one read of the activation
// banks then one saturating add per trit through the single row accumulator, items stalled;
// a row-ending byte then waits while an earlier result is held before its result is emitted.
// Reset clears control, counters, accumulator and sets configuration to its defaults;
// the activation banks are not cleared and hold unknown data until loaded.
`include "ternary_packed_matvec_core_defines.svh"

module ternary_packed_matvec_core import tpmv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tpmv_in_t         item,
	output logic             result_valid,
	input  logic             result_stall,
	output tpmv_out_t        result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	tpmv_cmd_t cmd;
	tpmv_sts_t sts;

	tpmv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.operation  (item.operation),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	tpmv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	`TPMV_ASSERT_IMP(a_emit_no_overwrite, cmd.emit, !(result_valid && result_stall), "pending result overwritten")
	`TPMV_ASSERT_NXT(a_emit_shows_result, cmd.emit, result_valid, "emitted row sum not presented")
	`TPMV_ASSERT_IMP(a_acc_blocks_input, cmd.acc_step, item_stall && !cmd.latch_byte && !cmd.load_act, "item taken while accumulating")

endmodule

>>> tb/testbench.sv
// Testbench for ternary_packed_matvec_core: directed table and sequences, then random beats checked by a predictor
module testbench;
	import tpmv_pkg::*;

	localparam int     CYCLE_LIMIT  = 2_000_000;
	localparam int     DRAIN_CYCLES = 12;
	localparam int     RANDOM_BEATS = 540;
	localparam int     IDLE_MAX     = 10;
	localparam int     OPENING_LEN  = 33;
	localparam int     LOADED_COLS  = 64;
	localparam longint SUM_MAX      = 64'sd2147483647;
	localparam longint SUM_MIN      = -64'sd2147483648;

	typedef enum logic { STEP_BEAT, STEP_REG } step_kind_t;

	typedef struct packed {
		step_kind_t       kind;
		logic             reg_sel;
		logic [CFG_W-1:0] reg_value;
		tpmv_in_t         beat;
		logic             typed;
		tpmv_out_t        want;
	} stim_step_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	tpmv_in_t         item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	tpmv_out_t        result;
	logic             cfg_we       = 1'b0;
	logic             cfg_index    = CFG_COLS;
	logic [CFG_W-1:0] cfg_data     = '0;

	// predictor state and its copy of the registers
	logic signed [ACT_W-1:0] act_mem [MAX_COLS];
	longint                  row_acc  = 0;
	int                      byte_pos = 0;
	logic [ROWS_W-1:0]       row_ctr  = '0;
	logic [COL_W-1:0]        cfg_cols = COL_W'(MAX_COLS);
	logic [ROWS_W-1:0]       cfg_rows = ROWS_W'(1024);

	tpmv_out_t   pending_rows [$];
	stim_step_t  opening_steps [OPENING_LEN];
	int unsigned mismatches  = 0;
	int unsigned beats_taken = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_cycles = 0;
	int unsigned gap_max     = IDLE_MAX;
	int unsigned stall_max   = IDLE_MAX;

	ternary_packed_matvec_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		tpmv_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_rows.size() == 0) begin
				$error("row_index: no row pending, got %0d", result.row_index);
				mismatches++;
			end else begin
				want = pending_rows.pop_front();
				if (result.row_sum !== want.row_sum) begin
					$error("row_sum: expected %0d, got %0d", want.row_sum, result.row_sum);
					mismatches++;
				end
				if (result.row_index !== want.row_index) begin
					$error("row_index: expected %0d, got %0d", want.row_index, result.row_index);
					mismatches++;
				end
				if (result.last_row !== want.last_row) begin
					$error("last_row: expected %0d, got %0d", want.last_row, result.last_row);
					mismatches++;
				end
			end
			hold_cycles = $urandom_range(0, stall_max);
		end else if (hold_cycles != 0) begin
			hold_cycles--;
		end
		result_stall <= (hold_cycles != 0);
	end

	function automatic logic advance_row_sum(input tpmv_in_t b, output tpmv_out_t row);
		int     cols;
		int     col;
		longint acc;
		logic   is_last;
		row = '0;
		if (b.operation == OP_LOAD) begin
			act_mem[b.act_index] = b.act_value;
			return 1'b0;
		end
		cols = int'(cfg_cols);
		if (cols == 0) cols = 1;
		if (cols > MAX_COLS) cols = MAX_COLS;
		acc = row_acc;
		for (int t = 0; t < TRITS; t++) begin
			col = byte_pos * TRITS + t;
			if (col < cols) begin
				if (b.weight_byte[t*TRIT_W +: TRIT_W] == TRIT_POS)
					acc = acc + act_mem[col];
				else if (b.weight_byte[t*TRIT_W +: TRIT_W] == TRIT_NEG)
					acc = acc - act_mem[col];
				if (acc > SUM_MAX) acc = SUM_MAX;
				if (acc < SUM_MIN) acc = SUM_MIN;
			end
		end
		row_acc = acc;
		if (byte_pos + 1 < (cols + TRITS - 1) / TRITS) begin
			byte_pos++;
			return 1'b0;
		end
		is_last = (row_ctr == cfg_rows - 1'b1);
		row.row_sum   = acc[SUM_W-1:0];
		row.row_index = row_ctr;
		row.last_row  = is_last;
		row_acc  = 0;
		byte_pos = 0;
		row_ctr  = is_last ? '0 : row_ctr + 1'b1;
		return 1'b1;
	endfunction

	function automatic tpmv_in_t load_beat(input logic [IDX_W-1:0] idx, input logic [ACT_W-1:0] value);
		tpmv_in_t b;
		b.operation   = OP_LOAD;
		b.act_index   = idx;
		b.act_value   = value;
		b.weight_byte = BYTE_W'($urandom);
		return b;
	endfunction

	function automatic tpmv_in_t weight_beat(input logic [BYTE_W-1:0] wb);
		tpmv_in_t b;
		b.operation   = OP_WEIGHT;
		b.act_index   = IDX_W'($urandom);
		b.act_value   = ACT_W'($urandom);
		b.weight_byte = wb;
		return b;
	endfunction

	function automatic stim_step_t reg_step(input logic sel, input logic [CFG_W-1:0] value);
		stim_step_t s;
		s = '0;
		s.kind      = STEP_REG;
		s.reg_sel   = sel;
		s.reg_value = value;
		return s;
	endfunction

	function automatic stim_step_t beat_step(input tpmv_in_t b);
		stim_step_t s;
		s = '0;
		s.kind = STEP_BEAT;
		s.beat = b;
		return s;
	endfunction

	function automatic stim_step_t row_step(input logic [BYTE_W-1:0] wb, input int sum,
	                                        input int idx, input logic is_last);
		stim_step_t s;
		s = beat_step(weight_beat(wb));
		s.typed          = 1'b1;
		s.want.row_sum   = sum;
		s.want.row_index = ROWS_W'(idx);
		s.want.last_row  = is_last;
		return s;
	endfunction

	task automatic send_beat(input tpmv_in_t beat, input logic typed, input tpmv_out_t want);
		int unsigned gap;
		tpmv_out_t   row;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		beats_taken++;
		if (advance_row_sum(beat, row))
			pending_rows.push_back(typed ? want : row);
	endtask

	task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
		item_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == CFG_COLS)
			cfg_cols = value[COL_W-1:0];
		else
			cfg_rows = value;
	endtask

	initial begin
		logic [ACT_W-1:0] value;
		int unsigned      start;

		opening_steps = '{
			reg_step(CFG_COLS, 16'd4),
			reg_step(CFG_ROWS, 16'd2),
			beat_step(load_beat(12'd0, 16'h7fff)),
			beat_step(load_beat(12'd1, 16'h8000)),
			beat_step(load_beat(12'd2, 16'h0001)),
			beat_step(load_beat(12'd3, 16'hffff)),
			beat_step(load_beat(12'd4, 16'd100)),
			beat_step(load_beat(12'd5, 16'hff38)),
			beat_step(load_beat(12'd6, 16'd7)),
			beat_step(load_beat(12'd7, 16'd9)),
			row_step(8'h55, -1, 0, 1'b0),
			row_step(8'haa, 1, 1, 1'b1),
			row_step(8'hff, 0, 0, 1'b0),
			row_step(8'h00, 0, 1, 1'b1),
			row_step(8'h09, 65535, 0, 1'b0),
			reg_step(CFG_COLS, 16'd0),
			row_step(8'hfe, -32767, 1, 1'b1),
			row_step(8'hfd, 32767, 0, 1'b0),
			reg_step(CFG_COLS, 16'd6),
			beat_step(weight_beat(8'h55)),
			row_step(8'h55, -101, 1, 1'b1),
			reg_step(CFG_COLS, 16'd8),
			beat_step(weight_beat(8'h01)),
			reg_step(CFG_COLS, 16'd4),
			row_step(8'h55, 32767, 0, 1'b0),
			reg_step(CFG_COLS, 16'd8),
			beat_step(weight_beat(8'h00)),
			beat_step(load_beat(12'd5, 16'd300)),
			row_step(8'h04, 300, 1, 1'b1),
			reg_step(CFG_ROWS, 16'd1),
			reg_step(CFG_COLS, 16'd4),
			row_step(8'h01, 32767, 0, 1'b1),
			row_step(8'h02, -32767, 0, 1'b1)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_steps[i]) begin
			if (opening_steps[i].kind == STEP_REG)
				write_reg(opening_steps[i].reg_sel, opening_steps[i].reg_value);
			else
				send_beat(opening_steps[i].beat, opening_steps[i].typed, opening_steps[i].want);
		end

		// load the low columns so every row reads only written entries
		for (int i = 0; i < LOADED_COLS; i++) begin
			case ($urandom_range(0, 7))
				0: value = 16'h7fff;
				1: value = 16'h8000;
				default: value = ACT_W'($urandom);
			endcase
			send_beat(load_beat(IDX_W'(i), value), 1'b0, '0);
		end

		// full and oversized column counts hold the row open, a lowered count ends it
		write_reg(CFG_ROWS, 16'hffff);
		write_reg(CFG_COLS, CFG_W'(MAX_COLS));
		repeat (2) send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);
		write_reg(CFG_COLS, 16'h1fff);
		repeat (2) send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);
		write_reg(CFG_COLS, 16'd4);
		send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);

		// drop the row count below the counter, then bring the counter back to zero
		write_reg(CFG_COLS, 16'd1);
		write_reg(CFG_ROWS, 16'd40);
		repeat (12) send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);
		write_reg(CFG_ROWS, 16'd3);
		repeat (5) send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);
		write_reg(CFG_ROWS, CFG_W'(row_ctr + ROWS_W'(1)));
		send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);

		start = beats_taken;
		while (beats_taken - start < RANDOM_BEATS) begin
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
			case ($urandom_range(0, 9))
				0: write_reg(CFG_COLS, '0);
				1: write_reg(CFG_COLS, CFG_W'($urandom_range(17, LOADED_COLS)));
				default: write_reg(CFG_COLS, CFG_W'($urandom_range(1, 16)));
			endcase
			case ($urandom_range(0, 9))
				0: write_reg(CFG_ROWS, '0);
				1: write_reg(CFG_ROWS, '1);
				default: write_reg(CFG_ROWS, CFG_W'($urandom_range(1, 6)));
			endcase
			repeat ($urandom_range(20, 60)) begin
				if ($urandom_range(0, 4) == 0)
					send_beat(load_beat(IDX_W'($urandom), ACT_W'($urandom)), 1'b0, '0);
				else
					send_beat(weight_beat(BYTE_W'($urandom)), 1'b0, '0);
			end
		end

		item_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
